### rtl/imbs_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizing for the I2C master byte sequencer.
// No dependencies; every other file imports this package.
package imbs_pkg;

   localparam int BUFFER_DEPTH = 512;
   localparam int ADDR_W = $clog2(BUFFER_DEPTH);
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int LEN_W = 9;
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // item modes
   localparam logic [1:0] MODE_BEGIN = 2'd0;
   localparam logic [1:0] MODE_PUSH = 2'd1;
   localparam logic [1:0] MODE_EVENT = 2'd2;

   // bus status codes
   localparam logic [3:0] ST_NONE = 4'd0;
   localparam logic [3:0] ST_START = 4'd1;
   localparam logic [3:0] ST_RESTART = 4'd2;
   localparam logic [3:0] ST_TXADDR_ACK = 4'd3;
   localparam logic [3:0] ST_TXADDR_NACK = 4'd4;
   localparam logic [3:0] ST_TXDATA_ACK = 4'd5;
   localparam logic [3:0] ST_TXDATA_NACK = 4'd6;
   localparam logic [3:0] ST_RXADDR_ACK = 4'd7;
   localparam logic [3:0] ST_RXADDR_NACK = 4'd8;
   localparam logic [3:0] ST_RXDATA_ACK = 4'd9;
   localparam logic [3:0] ST_RXDATA_NACK = 4'd10;
   localparam logic [3:0] ST_LOST = 4'd11;

   // result codes
   localparam logic [1:0] RES_NONE = 2'd0;
   localparam logic [1:0] RES_ACCEPTED = 2'd1;
   localparam logic [1:0] RES_BUSY = 2'd2;
   localparam logic [1:0] RES_FINISHED = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] address_byte;
      logic       read_not_write;
      logic [8:0] byte_count;
      logic       stop_at_end;
      logic [7:0] tx_byte;
      logic [3:0] bus_status;
      logic [7:0] rx_byte;
   } imbs_req_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       set_start;
      logic       clear_start;
      logic       set_stop;
      logic       set_ack;
      logic       clear_ack;
      logic       clear_event;
      logic       hold_event;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic [1:0] result_code;
   } imbs_rsp_type;

   // control actions decided when an item is taken; send_byte follows from the buffer
   typedef struct packed {
      logic       send_valid;
      logic       set_start;
      logic       clear_start;
      logic       set_stop;
      logic       set_ack;
      logic       clear_ack;
      logic       clear_event;
      logic       hold_event;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic [1:0] result_code;
   } imbs_ctrl_type;

endpackage

### rtl/imbs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response transfers.
// Depends on imbs_pkg for the payload types.
interface imbs_req_if import imbs_pkg::*; ();
   logic         valid;
   logic         ready;
   imbs_req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface imbs_rsp_if import imbs_pkg::*; ();
   logic         valid;
   logic         ready;
   imbs_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/imbs_tx_ram.sv
`timescale 1ns / 1ps
// Transmit byte buffer: one write port, one read port, registered read data.
// Depends on imbs_pkg for depth and address width.
module imbs_tx_ram import imbs_pkg::*; (
   input  logic       clock,
   input  logic       wr_en,
   input  addr_type   wr_addr,
   input  logic [7:0] wr_data,
   input  logic       rd_en,
   input  addr_type   rd_addr,
   output logic [7:0] rd_data
);

   logic [7:0] mem [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/imbs_control.sv
`timescale 1ns / 1ps
// Sequencer state and per-item decode: index/count registers, buffer
// write and read requests, control actions. Depends on imbs_pkg.
module imbs_control import imbs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  imbs_req_type  req,
   output imbs_ctrl_type ctrl,
   output logic          wr_en,
   output addr_type      wr_addr,
   output logic [7:0]    wr_data,
   output logic          rd_en,
   output addr_type      rd_addr
);

   localparam logic [CMP_W-1:0] LAST_LEN = CMP_W'(BUFFER_DEPTH - 1);
   localparam cnt_type CNT_ONE = CNT_W'(1);
   localparam cnt_type CNT_TWO = CNT_W'(2);
   localparam cnt_type CNT_DEPTH = CNT_W'(BUFFER_DEPTH);

   cnt_type send_index_ff, send_index_in;
   cnt_type fill_index_ff, fill_index_in;
   cnt_type total_bytes_ff, total_bytes_in;
   logic    stop_flag_ff, stop_flag_in;
   logic    busy_flag_ff, busy_flag_in;
   logic    reading_flag_ff, reading_flag_in;

   logic [CMP_W-1:0] len_sat;
   cnt_type          fill_rx;
   cnt_type          rd_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         send_index_ff <= '0;
         fill_index_ff <= '0;
         total_bytes_ff <= '0;
         stop_flag_ff <= 1'b0;
         busy_flag_ff <= 1'b0;
         reading_flag_ff <= 1'b0;
      end else begin
         send_index_ff <= send_index_in;
         fill_index_ff <= fill_index_in;
         total_bytes_ff <= total_bytes_in;
         stop_flag_ff <= stop_flag_in;
         busy_flag_ff <= busy_flag_in;
         reading_flag_ff <= reading_flag_in;
      end
   end

   // length on begin: zero on a read means a full buffer, long lengths saturate
   always_comb begin
      len_sat = CMP_W'(req.byte_count);
      if (req.read_not_write && (len_sat == '0)) begin
         len_sat = LAST_LEN;
      end
      if (len_sat > LAST_LEN) begin
         len_sat = LAST_LEN;
      end
   end

   // receive count after a data byte, holding at the total
   assign fill_rx = (fill_index_ff < total_bytes_ff) ? fill_index_ff + CNT_ONE
                                                     : fill_index_ff;

   always_comb begin
      send_index_in = send_index_ff;
      fill_index_in = fill_index_ff;
      total_bytes_in = total_bytes_ff;
      stop_flag_in = stop_flag_ff;
      busy_flag_in = busy_flag_ff;
      reading_flag_in = reading_flag_ff;
      ctrl = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_index = send_index_ff;

      if (accept) begin
         unique case (req.mode)
            MODE_BEGIN: begin
               if (busy_flag_ff) begin
                  ctrl.result_code = RES_BUSY;
               end else begin
                  busy_flag_in = 1'b1;
                  reading_flag_in = req.read_not_write;
                  stop_flag_in = req.read_not_write | req.stop_at_end;
                  total_bytes_in = CNT_W'(len_sat) + CNT_ONE;
                  send_index_in = '0;
                  fill_index_in = CNT_ONE;
                  wr_en = 1'b1;
                  wr_addr = '0;
                  wr_data = {req.address_byte[7:1], req.read_not_write};
                  ctrl.set_start = 1'b1;
                  ctrl.clear_event = req.read_not_write;
                  ctrl.result_code = RES_ACCEPTED;
               end
            end
            MODE_PUSH: begin
               if (busy_flag_ff && !reading_flag_ff && (fill_index_ff < total_bytes_ff)
                   && (fill_index_ff < CNT_DEPTH)) begin
                  wr_en = 1'b1;
                  wr_addr = fill_index_ff[ADDR_W-1:0];
                  wr_data = req.tx_byte;
                  fill_index_in = fill_index_ff + CNT_ONE;
               end
            end
            MODE_EVENT: begin
               unique case (req.bus_status)
                  ST_NONE, ST_LOST: begin
                     ctrl.clear_event = 1'b1;
                  end
                  ST_START, ST_RESTART: begin
                     rd_index = '0;
                     send_index_in = CNT_ONE;
                     ctrl.send_valid = 1'b1;
                     ctrl.clear_start = 1'b1;
                     ctrl.clear_event = 1'b1;
                  end
                  ST_TXADDR_ACK, ST_TXDATA_ACK: begin
                     priority if (send_index_ff < fill_index_ff) begin
                        send_index_in = send_index_ff + CNT_ONE;
                        ctrl.send_valid = 1'b1;
                        ctrl.clear_event = 1'b1;
                     end else if (send_index_ff < total_bytes_ff) begin
                        ctrl.hold_event = 1'b1;
                     end else begin
                        ctrl.set_stop = stop_flag_ff;
                        ctrl.clear_event = stop_flag_ff;
                        ctrl.hold_event = !stop_flag_ff;
                        ctrl.result_code = busy_flag_ff ? RES_FINISHED : RES_NONE;
                        busy_flag_in = 1'b0;
                     end
                  end
                  ST_TXADDR_NACK, ST_RXADDR_NACK: begin
                     ctrl.set_start = 1'b1;
                     send_index_in = '0;
                     ctrl.clear_event = 1'b1;
                  end
                  ST_TXDATA_NACK: begin
                     ctrl.set_stop = stop_flag_ff;
                     ctrl.clear_event = 1'b1;
                     ctrl.result_code = busy_flag_ff ? RES_FINISHED : RES_NONE;
                     busy_flag_in = 1'b0;
                  end
                  ST_RXADDR_ACK: begin
                     // single-byte read drops acknowledge right away
                     ctrl.clear_ack = (total_bytes_ff <= CNT_TWO);
                     ctrl.set_ack = (total_bytes_ff > CNT_TWO);
                     ctrl.clear_event = 1'b1;
                  end
                  ST_RXDATA_ACK: begin
                     ctrl.rx_valid = 1'b1;
                     ctrl.rx_data = req.rx_byte;
                     fill_index_in = fill_rx;
                     ctrl.clear_ack = (total_bytes_ff != '0)
                                      && (fill_rx == total_bytes_ff - CNT_ONE);
                     ctrl.clear_event = 1'b1;
                  end
                  ST_RXDATA_NACK: begin
                     ctrl.rx_valid = 1'b1;
                     ctrl.rx_data = req.rx_byte;
                     fill_index_in = fill_rx;
                     ctrl.set_stop = 1'b1;
                     ctrl.clear_event = 1'b1;
                     ctrl.result_code = busy_flag_ff ? RES_FINISHED : RES_NONE;
                     busy_flag_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // send index stays below the depth whenever a byte is sent
   assign rd_en = ctrl.send_valid;
   assign rd_addr = rd_index[ADDR_W-1:0];

endmodule

### rtl/imbs_out_stage.sv
`timescale 1ns / 1ps
// Two-entry result path: buffer-read stage, then the response register.
// Merges buffer read data into send_byte. Depends on imbs_pkg.
module imbs_out_stage import imbs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  imbs_ctrl_type ctrl,
   input  logic [7:0]    rd_data,
   output logic          in_ready,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output imbs_rsp_type  rsp_data
);

   logic          s1_valid_ff, s1_valid_in;
   imbs_ctrl_type s1_ctrl_ff;
   logic          out_valid_ff, out_valid_in;
   imbs_rsp_type  out_data_ff, out_data_in;
   logic          advance;

   assign advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign in_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // rd_data holds while the stage waits: the read fires only on a transfer in
   always_comb begin
      out_data_in.send_valid = s1_ctrl_ff.send_valid;
      out_data_in.send_byte = s1_ctrl_ff.send_valid ? rd_data : 8'h00;
      out_data_in.set_start = s1_ctrl_ff.set_start;
      out_data_in.clear_start = s1_ctrl_ff.clear_start;
      out_data_in.set_stop = s1_ctrl_ff.set_stop;
      out_data_in.set_ack = s1_ctrl_ff.set_ack;
      out_data_in.clear_ack = s1_ctrl_ff.clear_ack;
      out_data_in.clear_event = s1_ctrl_ff.clear_event;
      out_data_in.hold_event = s1_ctrl_ff.hold_event;
      out_data_in.rx_valid = s1_ctrl_ff.rx_valid;
      out_data_in.rx_data = s1_ctrl_ff.rx_data;
      out_data_in.result_code = s1_ctrl_ff.result_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff <= ctrl;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

endmodule

### rtl/i2c_master_byte_sequencer.sv
`timescale 1ns / 1ps
// Byte-level I2C master sequencer, top level.
// Depends on imbs_pkg, imbs_if, imbs_tx_ram, imbs_control, imbs_out_stage.
//
// Usage:
//   req_ch carries one item per transfer: begin a transfer, push a transmit
//   byte, or report a bus status event. rsp_ch returns exactly one result per
//   item, in order: bus control actions, the byte to send, a received byte
//   and a result code.
//   A result is registered in the buffer-read stage, then in the response register.
//   Throughput: one item per cycle while results are taken; the limit is the
//   single read port of the transmit buffer, read in the cycle the item is taken.
//   Stall: up to two results are held (buffer-read stage plus response
//   register); with both full and rsp_ch.ready low, req_ch.ready drops and
//   rises again in the cycle the response is taken.
//   Reset: synchronous, clears indexes, counts and flags and empties the
//   result path. Transmit buffer contents are not cleared; the user must see that
//   an entry is only read after a begin or push has written it (not enforced).
module i2c_master_byte_sequencer import imbs_pkg::*; (
   input logic      clock,
   input logic      reset,
   imbs_req_if.sink req_ch,
   imbs_rsp_if.source rsp_ch
);

   logic          accept;
   imbs_ctrl_type ctrl;
   logic          wr_en;
   addr_type      wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   addr_type      rd_addr;
   logic [7:0]    rd_data;
   logic          in_ready;

   assign req_ch.ready = in_ready;
   assign accept = req_ch.valid && in_ready;

   imbs_control u_control (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_ch.data),
      .ctrl    (ctrl),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr)
   );

   imbs_tx_ram u_tx_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   imbs_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ctrl      (ctrl),
      .rd_data   (rd_data),
      .in_ready  (in_ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_ch.data)
   );

`ifndef ASSERT_OFF
   a_ack_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.data.set_ack && rsp_ch.data.clear_ack))
      else $error("set_ack and clear_ack both asserted");

   a_event_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.data.clear_event && rsp_ch.data.hold_event))
      else $error("clear_event and hold_event both asserted");

   a_send_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.data.send_valid) |-> (rsp_ch.data.send_byte == 8'h00))
      else $error("send_byte nonzero without send_valid");

   a_ready_after_take: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready) |-> req_ch.ready)
      else $error("request side stalled while a response is taken");
`endif

endmodule
